/* sv/clwsq_pkg.sv */
// Shared types, constants and helpers for the character LCD write sequencer.
package clwsq_pkg;

	localparam int ROW_LENGTH_DEF = 16;
	localparam int JOBQ_DEPTH     = 2;
	localparam int RESQ_DEPTH     = 2;

	localparam logic [7:0] SET_ADDR_CMD = 8'h80;
	localparam logic [7:0] ROW1_BASE    = 8'h40;
	localparam logic [7:0] ROW0_BASE    = 8'h00;

	localparam logic [1:0] CMD_BYTE = 2'd0;
	localparam logic [1:0] CMD_DATA = 2'd1;
	localparam logic [1:0] CMD_WRAP = 2'd2;
	localparam logic [1:0] CMD_MOVE = 2'd3;

	// One byte transfer for the back end
	typedef struct packed {
		logic       rs;
		logic [7:0] value;
		logic       last;
	} job_t;

	// One pin state on the result side
	typedef struct packed {
		logic       rs;
		logic       en;
		logic [7:0] bus;
		logic       last;
	} step_t;

	localparam int JOB_W  = $bits(job_t);
	localparam int STEP_W = $bits(step_t);

	// Set-DDRAM-address command for a row and column
	function automatic logic [7:0] cursor_code(input logic [1:0] row, input logic [5:0] col);
		logic [7:0] pos;
		case (row)
			2'd0:    pos = ROW0_BASE | {2'b00, col};
			2'd1:    pos = ROW1_BASE | {2'b00, col};
			default: pos = ROW0_BASE;
		endcase
		return pos | SET_ADDR_CMD;
	endfunction

endpackage

/* sv/clwsq_fifo.sv */
// Small first-word-fall-through queue used between the block's stages.
module clwsq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= CNTW'(count_q + 1'b1);
			end else if (do_rd && !do_wr) begin
				count_q <= CNTW'(count_q - 1'b1);
			end
		end
	end

endmodule

/* sv/clwsq_front.sv */
// Front end: accepts requests, tracks line wrap and splits them into byte jobs.
module clwsq_front
	import clwsq_pkg::*;
#(
	parameter int ROW_LENGTH = ROW_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] cmd,
	input  logic [7:0] byte_value,
	input  logic [1:0] target_row,
	input  logic [5:0] target_column,
	output job_t       job,
	output logic       job_valid,
	input  logic       job_full
);

	localparam int CW = $clog2(ROW_LENGTH + 1);

	logic [CW-1:0] col_q;
	logic          row_q;
	logic          pend_q;
	job_t          pend_job_q;
	logic          wrap_now;
	logic          accept;

	assign wrap_now = (col_q >= CW'(ROW_LENGTH));
	assign full     = pend_q | job_full;
	assign accept   = push & ~full;

	always_comb begin
		job       = pend_job_q;
		job_valid = 1'b0;
		if (pend_q) begin
			job_valid = ~job_full;
		end else begin
			job_valid = push & ~job_full;
			case (cmd)
				CMD_BYTE: job = '{rs: 1'b0, value: byte_value, last: 1'b1};
				CMD_DATA: job = '{rs: 1'b1, value: byte_value, last: 1'b1};
				CMD_WRAP: begin
					if (wrap_now) begin
						job = '{rs: 1'b0, value: cursor_code({1'b0, ~row_q}, 6'd0),
							last: 1'b0};
					end else begin
						job = '{rs: 1'b1, value: byte_value, last: 1'b1};
					end
				end
				CMD_MOVE: job = '{rs: 1'b0, value: cursor_code(target_row, target_column),
					last: 1'b1};
				default:  job = pend_job_q;
			endcase
		end
	end

	// Hold the data byte that follows a wrap cursor move
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_job_q <= '{rs: 1'b1, value: byte_value, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (accept && cmd == CMD_WRAP) begin
				if (wrap_now) begin
					row_q  <= ~row_q;
					col_q  <= CW'(1);
					pend_q <= 1'b1;
				end else begin
					col_q <= CW'(col_q + 1'b1);
				end
			end else if (pend_q && !job_full) begin
				pend_q <= 1'b0;
			end
		end
	end

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= CW'(ROW_LENGTH))
		else $error("column count past row length");

	a_pend_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> full)
		else $error("request taken while a wrap byte is pending");

endmodule

/* sv/clwsq_back.sv */
// Back end: plays one byte job out as a sequence of pin states.
module clwsq_back
	import clwsq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  four_bit_bus,
	input  job_t  job,
	input  logic  job_empty,
	output logic  job_pop,
	output step_t step,
	output logic  step_valid,
	input  logic  step_full
);

	localparam logic [2:0] STEP_RS     = 3'd0;
	localparam logic [2:0] STEP_EN_HI  = 3'd1;
	localparam logic [2:0] STEP_BUS_HI = 3'd2;
	localparam logic [2:0] STEP_EN_LO  = 3'd3;
	localparam logic [2:0] STEP_EN_HI2 = 3'd4;
	localparam logic [2:0] STEP_BUS_LO = 3'd5;
	localparam logic [2:0] STEP_EN_LO2 = 3'd6;

	logic       busy_q;
	job_t       job_q;
	logic [2:0] step_q;
	logic       rs_q, en_q;
	logic [7:0] bus_q;
	logic       rs_n, en_n;
	logic [7:0] bus_n;
	logic       final_step;

	assign job_pop    = ~busy_q & ~job_empty;
	assign step_valid = busy_q & ~step_full;
	assign final_step = four_bit_bus ? (step_q == STEP_EN_LO2) : (step_q == STEP_EN_LO);

	always_comb begin
		rs_n  = rs_q;
		en_n  = en_q;
		bus_n = bus_q;
		case (step_q)
			STEP_RS:                 rs_n = job_q.rs;
			STEP_EN_HI, STEP_EN_HI2: en_n = 1'b1;
			STEP_EN_LO, STEP_EN_LO2: en_n = 1'b0;
			STEP_BUS_HI: bus_n = four_bit_bus ? {bus_q[7:4], job_q.value[7:4]} : job_q.value;
			STEP_BUS_LO: bus_n = {bus_q[7:4], job_q.value[3:0]};
			default: ;
		endcase
		step = '{rs: rs_n, en: en_n, bus: bus_n, last: job_q.last & final_step};
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_RS;
			rs_q   <= 1'b0;
			en_q   <= 1'b0;
			bus_q  <= '0;
		end else if (job_pop) begin
			busy_q <= 1'b1;
			step_q <= STEP_RS;
		end else if (step_valid) begin
			rs_q  <= rs_n;
			en_q  <= en_n;
			bus_q <= bus_n;
			if (final_step) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= 3'(step_q + 1'b1);
			end
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q <= STEP_EN_LO2))
		else $error("step index out of range");

	a_byte_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !four_bit_bus) |-> (step_q <= STEP_EN_LO))
		else $error("byte-mode sequence ran past its last step");

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> (busy_q && step_q == STEP_RS))
		else $error("loaded job did not start at the first step");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step_valid && final_step) |=> !busy_q)
		else $error("sequencer stayed busy after its final step");

endmodule

/* sv/char_lcd_write_sequencer_unit.sv */
// Top level of the character LCD write sequencer.
// A taken request goes through the job queue, the back-end job register and the result queue.
// Throughput: one pin state per cycle from the step sequencer while the result queue has room;
// a request gives 4 or 7 states (8- or 4-bit bus), 8 or 14 with a line wrap, none as a job loads.
// Reset clears the wrap column and row, the pin levels, both queues and the bus-width
// register (8-bit bus).
module char_lcd_write_sequencer_unit
	import clwsq_pkg::*;
#(
	parameter int ROW_LENGTH = ROW_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_write_enable,
	input  logic       cfg_write_data,
	// request side
	input  logic       push,
	output logic       full,
	input  logic [1:0] cmd,
	input  logic [7:0] byte_value,
	input  logic [1:0] target_row,
	input  logic [5:0] target_column,
	// pin-state side
	output logic       empty,
	input  logic       pop,
	output logic       register_select,
	output logic       enable_pin,
	output logic [7:0] data_bus,
	output logic       last_step
);

	logic  four_bit_bus_q;

	job_t  fe_job;
	logic  fe_job_valid;
	logic  jq_full;
	job_t  jq_job;
	logic  jq_empty;
	logic  be_job_pop;

	step_t be_step;
	logic  be_step_valid;
	logic  rq_full;
	step_t rq_step;

	// Bus-width register; write it only while the block is idle (the block does not enforce this)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_bit_bus_q <= 1'b0;
		end else if (cfg_write_enable) begin
			four_bit_bus_q <= cfg_write_data;
		end
	end

	// Front end: take requests, advance wrap state, issue byte jobs
	clwsq_front #(
		.ROW_LENGTH(ROW_LENGTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.cmd           (cmd),
		.byte_value    (byte_value),
		.target_row    (target_row),
		.target_column (target_column),
		.job           (fe_job),
		.job_valid     (fe_job_valid),
		.job_full      (jq_full)
	);

	// Job queue decouples request intake from pin sequencing
	clwsq_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(JOBQ_DEPTH)
	) u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fe_job_valid),
		.wr_data (fe_job),
		.full    (jq_full),
		.rd_en   (be_job_pop),
		.rd_data (jq_job),
		.empty   (jq_empty)
	);

	// Back end: one pin state per cycle while a job is loaded and the result queue has room
	clwsq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.four_bit_bus (four_bit_bus_q),
		.job          (jq_job),
		.job_empty    (jq_empty),
		.job_pop      (be_job_pop),
		.step         (be_step),
		.step_valid   (be_step_valid),
		.step_full    (rq_full)
	);

	// Result queue: hold pin states until each beat is popped
	clwsq_fifo #(
		.WIDTH(STEP_W),
		.DEPTH(RESQ_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (be_step_valid),
		.wr_data (be_step),
		.full    (rq_full),
		.rd_en   (pop),
		.rd_data (rq_step),
		.empty   (empty)
	);

	assign register_select = rq_step.rs;
	assign enable_pin      = rq_step.en;
	assign data_bus        = rq_step.bus;
	assign last_step       = rq_step.last;

endmodule
